[hw/rtl/nncc_pkg.sv]
package nncc_pkg;

   // default geometry and store size
   localparam int PatchWDefault      = 15;
   localparam int PatchHDefault      = 15;
   localparam int MaxExamplesDefault = 256;

   // pixel count field of a queued command, wide enough for a 32x32 patch
   localparam int CountW = 11;

   // register reset values
   localparam logic [8:0] CapacityReset = 9'd200;
   localparam logic [7:0] FixedReset    = 8'd50;

   // one in Q1.16
   localparam logic [16:0] OneQ16 = 17'h10000;

   typedef enum logic [1:0] {
      REQ_ADD_POS  = 2'd0,
      REQ_ADD_NEG  = 2'd1,
      REQ_CLASSIFY = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_kind_type;

   typedef enum logic [0:0] {
      CSR_CAPACITY = 1'b0,
      CSR_FIXED    = 1'b1
   } csr_index_type;

   typedef enum logic {
      MATH_SQRT = 1'b0,
      MATH_DIV  = 1'b1
   } math_op_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_ADDR,
      BK_COPY,
      BK_SCAN,
      BK_ACC,
      BK_MUL,
      BK_SQRT,
      BK_DIV,
      BK_NEXT,
      BK_CONF,
      BK_CDIV,
      BK_RESULT
   } back_state_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic signed [7:0] pixel;
      logic              last_pixel;
   } req_word_type;

   typedef struct packed {
      logic [15:0] confidence;
      logic [8:0]  positive_count;
      logic [8:0]  negative_count;
   } rsp_word_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [CountW-1:0] count;
   } cmd_word_type;

endpackage

[hw/rtl/nncc_math.sv]
module nncc_math #(
   parameter int RootW = 22
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  nncc_pkg::math_op_type        op,
   input  logic [2*RootW-1:0]           a_in,
   input  logic [RootW-1:0]             divisor,
   output logic                         done,
   output logic [2*RootW-1:0]           result
);
   import nncc_pkg::*;

   localparam int StepW = $clog2(RootW + 17);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   math_op_type          op_ff, op_in;
   logic [StepW-1:0]     cnt_ff, cnt_in;
   logic [2*RootW-1:0]   acc_ff, acc_in;
   logic [2*RootW-1:0]   res_ff, res_in;
   logic [RootW:0]       rem_ff, rem_in;
   logic [RootW-1:0]     den_ff, den_in;
   logic [RootW+2:0]     sq_rem, sq_trial;
   logic [RootW:0]       dv_rem, dv_den;

   // one root digit or one quotient bit per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      sq_rem   = {rem_ff, acc_ff[2*RootW-1 -: 2]};
      sq_trial = {1'b0, res_ff[RootW-1:0], 2'b01};
      dv_rem   = {rem_ff[RootW-1:0], acc_ff[2*RootW-1]};
      dv_den   = {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         op_in   = op;
         rem_in  = '0;
         res_in  = '0;
         den_in  = divisor;
         if (op == MATH_SQRT) begin
            acc_in = a_in;
            cnt_in = StepW'(RootW);
         end else begin
            acc_in = a_in << (RootW - 16);
            cnt_in = StepW'(RootW + 16);
         end
      end else if (busy_ff) begin
         if (op_ff == MATH_SQRT) begin
            acc_in = acc_ff << 2;
            if (sq_rem >= sq_trial) begin
               rem_in = (RootW+1)'(sq_rem - sq_trial);
               res_in = {res_ff[2*RootW-2:0], 1'b1};
            end else begin
               rem_in = (RootW+1)'(sq_rem);
               res_in = {res_ff[2*RootW-2:0], 1'b0};
            end
         end else begin
            acc_in = acc_ff << 1;
            if (dv_rem >= dv_den) begin
               rem_in = dv_rem - dv_den;
               res_in = {res_ff[2*RootW-2:0], 1'b1};
            end else begin
               rem_in = dv_rem;
               res_in = {res_ff[2*RootW-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[hw/rtl/nncc_cmd_queue.sv]
module nncc_cmd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  nncc_pkg::cmd_word_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output nncc_pkg::cmd_word_type pop_data
);
   import nncc_pkg::*;

   localparam int Depth = 2;
   localparam int PtrW  = $clog2(Depth);

   cmd_word_type          entry_ff [Depth];
   logic [PtrW-1:0]       wptr_ff, wptr_in;
   logic [PtrW-1:0]       rptr_ff, rptr_in;
   logic [PtrW:0]         fill_ff, fill_in;
   logic                  do_push, do_pop;

   // pointer and fill bookkeeping
   always_comb begin
      do_push = push_valid && !full;
      do_pop  = pop && pop_valid;
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      fill_in = fill_ff + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_data;
   end

   assign full      = (fill_ff == (PtrW+1)'(Depth));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entry_ff[rptr_ff];

endmodule

[hw/rtl/nncc_front.sv]
module nncc_front #(
   parameter int Pix = 225
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  nncc_pkg::req_word_type  req_data,
   output logic                    push_valid,
   output nncc_pkg::cmd_word_type  push_data,
   input  logic                    queue_full,
   input  logic                    release_in,
   input  logic [$clog2(Pix)-1:0]  q_addr,
   output logic signed [7:0]       q_data
);
   import nncc_pkg::*;

   localparam int PixW = $clog2(Pix + 1);
   localparam int QiW  = $clog2(Pix);

   logic signed [7:0] qmem [Pix];
   logic [PixW-1:0]   cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              accept;
   logic              in_range;

   // pixel collection; a patch is held until the back end is done with it
   always_comb begin
      accept     = req_valid && !req_stall;
      in_range   = (cnt_ff < PixW'(Pix));
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      push_valid = accept && req_data.last_pixel;
      push_data.kind  = req_kind_type'(req_data.req_type);
      push_data.count = in_range ? CountW'(cnt_ff + 1'b1) : CountW'(cnt_ff);
      if (accept) begin
         if (req_data.last_pixel) begin
            cnt_in  = '0;
            busy_in = 1'b1;
         end else if (in_range) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (release_in) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   // query patch buffer
   always_ff @(posedge clock) begin
      if (accept && in_range) qmem[QiW'(cnt_ff)] <= req_data.pixel;
      q_data <= qmem[q_addr];
   end

   assign req_stall = busy_ff || queue_full;

endmodule

[hw/rtl/nncc_back.sv]
module nncc_back #(
   parameter int PatchW      = 15,
   parameter int PatchH      = 15,
   parameter int MaxExamples = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   input  nncc_pkg::cmd_word_type             cmd_data,
   output logic                               cmd_pop,
   output logic [$clog2(PatchW*PatchH)-1:0]   q_addr,
   input  logic signed [7:0]                  q_data,
   input  logic [8:0]                         cap_cfg,
   input  logic [7:0]                         fixed_cfg,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output nncc_pkg::rsp_word_type             rsp_data,
   output logic                               release_out
);
   import nncc_pkg::*;

   localparam int Pix   = PatchW * PatchH;
   localparam int PixW  = $clog2(Pix + 1);
   localparam int QiW   = $clog2(Pix);
   localparam int IdxW  = $clog2(MaxExamples);
   localparam int CntW  = $clog2(MaxExamples + 1);
   localparam int Depth = MaxExamples * Pix;
   localparam int AddrW = $clog2(Depth);
   localparam int SumW  = $clog2(Pix * 16384 + 1);
   localparam int RootW = (SumW > 18) ? SumW : 18;

   // example stores
   logic signed [7:0] pos_mem [Depth];
   logic signed [7:0] neg_mem [Depth];
   logic signed [7:0] pos_rd_ff, neg_rd_ff;

   back_state_type      state_ff, state_in;
   req_kind_type        kind_ff, kind_in;
   logic [PixW-1:0]     count_ff, count_in;
   logic                side_ff, side_in;
   logic [CntW-1:0]     ex_ff, ex_in;
   logic [AddrW-1:0]    base_ff, base_in;
   logic [PixW-1:0]     pix_ff, pix_in;
   logic [IdxW-1:0]     slot_ff, slot_in;
   logic [IdxW-1:0]     pwi_ff, pwi_in, nwi_ff, nwi_in;
   logic [CntW-1:0]     pvc_ff, pvc_in, nvc_ff, nvc_in;
   logic [RootW-1:0]    s1_ff, s1_in, s2_ff, s2_in;
   logic signed [RootW:0] s3_ff, s3_in;
   logic [16:0]         bneg_ff, bneg_in, bpos_ff, bpos_in;
   logic [15:0]         conf_ff, conf_in;
   logic                rd_valid_ff, rd_in_ff;
   logic [AddrW-1:0]    rd_addr_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_word_type        rsp_data_ff, rsp_data_in;
   logic                done_ff, done_in;

   logic [CntW-1:0]     cap_use, wrap_slot, cur_wi, cur_vc, slot_c, next_idx;
   logic                issue;
   logic [AddrW-1:0]    mem_raddr;
   logic signed [7:0]   q_val, e_val;
   logic signed [15:0]  paa, pbb, pab;
   logic                mac_en;
   logic                pos_we, neg_we;
   logic [16:0]         n_val, p_val;
   logic [RootW-1:0]    root;

   logic                math_start;
   math_op_type         math_op;
   logic [2*RootW-1:0]  math_a;
   logic [RootW-1:0]    math_den;
   logic                math_done;
   logic [2*RootW-1:0]  math_res;

   nncc_math #(.RootW(RootW)) u_math (
      .clock   (clock),
      .reset   (reset),
      .start   (math_start),
      .op      (math_op),
      .a_in    (math_a),
      .divisor (math_den),
      .done    (math_done),
      .result  (math_res)
   );

   // capacity in use and ring wrap point
   always_comb begin
      if (cap_cfg == '0) cap_use = CntW'(1);
      else if (int'(cap_cfg) > MaxExamples) cap_use = CntW'(MaxExamples);
      else cap_use = CntW'(cap_cfg);
      wrap_slot = (int'(fixed_cfg) < int'(cap_use)) ? CntW'(fixed_cfg) : '0;
      cur_wi    = (cmd_data.kind == REQ_ADD_POS) ? CntW'(pwi_ff) : CntW'(nwi_ff);
      cur_vc    = (cmd_data.kind == REQ_ADD_POS) ? pvc_ff : nvc_ff;
      slot_c    = (cur_wi >= cap_use) ? wrap_slot : cur_wi;
      next_idx  = slot_c + 1'b1;
   end

   // read pipeline and multiply-accumulate
   always_comb begin
      issue     = (state_ff == BK_COPY || state_ff == BK_ACC) && (pix_ff < PixW'(Pix));
      mem_raddr = base_ff + AddrW'(pix_ff);
      q_addr    = QiW'(pix_ff);
      q_val     = rd_in_ff ? q_data : 8'sd0;
      e_val     = side_ff ? pos_rd_ff : neg_rd_ff;
      paa       = q_val * q_val;
      pbb       = e_val * e_val;
      pab       = q_val * e_val;
      mac_en    = rd_valid_ff && (state_ff == BK_ACC);
      pos_we    = rd_valid_ff && (state_ff == BK_COPY) && (kind_ff == REQ_ADD_POS);
      neg_we    = rd_valid_ff && (state_ff == BK_COPY) && (kind_ff == REQ_ADD_NEG);
      n_val     = OneQ16 - bneg_ff;
      p_val     = OneQ16 - bpos_ff;
      root      = math_res[RootW-1:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      count_in     = count_ff;
      side_in      = side_ff;
      ex_in        = ex_ff;
      base_in      = base_ff;
      pix_in       = pix_ff;
      slot_in      = slot_ff;
      pwi_in       = pwi_ff;
      nwi_in       = nwi_ff;
      pvc_in       = pvc_ff;
      nvc_in       = nvc_ff;
      s1_in        = mac_en ? s1_ff + RootW'($unsigned(paa)) : s1_ff;
      s2_in        = mac_en ? s2_ff + RootW'($unsigned(pbb)) : s2_ff;
      s3_in        = mac_en ? s3_ff + (RootW+1)'(pab) : s3_ff;
      bneg_in      = bneg_ff;
      bpos_in      = bpos_ff;
      conf_in      = conf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      done_in      = 1'b0;
      cmd_pop      = 1'b0;
      math_start   = 1'b0;
      math_op      = MATH_SQRT;
      math_a       = '0;
      math_den     = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               kind_in  = cmd_data.kind;
               count_in = PixW'(cmd_data.count);
               conf_in  = '0;
               unique case (cmd_data.kind)
                  REQ_ADD_POS, REQ_ADD_NEG: begin
                     slot_in = IdxW'(slot_c);
                     if (cmd_data.kind == REQ_ADD_POS) begin
                        if (cur_vc < cap_use) pvc_in = next_idx;
                        pwi_in = (next_idx >= cap_use) ? IdxW'(wrap_slot) : IdxW'(next_idx);
                     end else begin
                        if (cur_vc < cap_use) nvc_in = next_idx;
                        nwi_in = (next_idx >= cap_use) ? IdxW'(wrap_slot) : IdxW'(next_idx);
                     end
                     state_in = BK_ADDR;
                  end
                  REQ_CLASSIFY: begin
                     side_in  = 1'b0;
                     ex_in    = '0;
                     base_in  = '0;
                     bneg_in  = '0;
                     bpos_in  = '0;
                     state_in = BK_SCAN;
                  end
                  REQ_CLEAR: begin
                     pwi_in   = '0;
                     nwi_in   = '0;
                     pvc_in   = '0;
                     nvc_in   = '0;
                     state_in = BK_RESULT;
                  end
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_ADDR: begin
            base_in  = AddrW'(slot_ff * Pix);
            pix_in   = '0;
            state_in = BK_COPY;
         end
         BK_COPY: begin
            if (issue) pix_in = pix_ff + 1'b1;
            else state_in = BK_RESULT;
         end
         BK_SCAN: begin
            if (ex_ff >= (side_ff ? pvc_ff : nvc_ff)) begin
               if (!side_ff) begin
                  side_in = 1'b1;
                  ex_in   = '0;
                  base_in = '0;
               end else begin
                  state_in = BK_CONF;
               end
            end else begin
               pix_in   = '0;
               s1_in    = '0;
               s2_in    = '0;
               s3_in    = '0;
               state_in = BK_ACC;
            end
         end
         BK_ACC: begin
            if (issue) pix_in = pix_ff + 1'b1;
            else state_in = BK_MUL;
         end
         BK_MUL: begin
            if (s1_ff == '0 || s2_ff == '0 || s3_ff[RootW] || s3_ff == '0) begin
               state_in = BK_NEXT;
            end else begin
               math_start = 1'b1;
               math_op    = MATH_SQRT;
               math_a     = (2*RootW)'(s1_ff) * (2*RootW)'(s2_ff);
               state_in   = BK_SQRT;
            end
         end
         BK_SQRT: begin
            if (math_done) begin
               if (root == '0) begin
                  state_in = BK_NEXT;
               end else begin
                  math_start = 1'b1;
                  math_op    = MATH_DIV;
                  math_a     = (2*RootW)'({s3_ff[RootW-1:0], 16'h0000});
                  math_den   = root;
                  state_in   = BK_DIV;
               end
            end
         end
         BK_DIV: begin
            if (math_done) begin
               if (side_ff) begin
                  if (math_res[16:0] > bpos_ff) bpos_in = math_res[16:0];
               end else begin
                  if (math_res[16:0] > bneg_ff) bneg_in = math_res[16:0];
               end
               state_in = BK_NEXT;
            end
         end
         BK_NEXT: begin
            ex_in    = ex_ff + 1'b1;
            base_in  = base_ff + AddrW'(Pix);
            state_in = BK_SCAN;
         end
         BK_CONF: begin
            if (n_val == '0) begin
               conf_in  = '0;
               state_in = BK_RESULT;
            end else begin
               math_start = 1'b1;
               math_op    = MATH_DIV;
               math_a     = (2*RootW)'({n_val, 16'h0000});
               math_den   = RootW'({1'b0, n_val} + {1'b0, p_val});
               state_in   = BK_CDIV;
            end
         end
         BK_CDIV: begin
            if (math_done) begin
               conf_in  = (|math_res[2*RootW-1:16]) ? 16'hFFFF : math_res[15:0];
               state_in = BK_RESULT;
            end
         end
         BK_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.confidence      = conf_ff;
               rsp_data_in.positive_count  = 9'(pvc_ff);
               rsp_data_in.negative_count  = 9'(nvc_ff);
               done_in                     = 1'b1;
               state_in                    = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         pwi_ff       <= '0;
         nwi_ff       <= '0;
         pvc_ff       <= '0;
         nvc_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pwi_ff       <= pwi_in;
         nwi_ff       <= nwi_in;
         pvc_ff       <= pvc_in;
         nvc_ff       <= nvc_in;
         rd_valid_ff  <= issue;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      count_ff    <= count_in;
      side_ff     <= side_in;
      ex_ff       <= ex_in;
      base_ff     <= base_in;
      pix_ff      <= pix_in;
      slot_ff     <= slot_in;
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      bneg_ff     <= bneg_in;
      bpos_ff     <= bpos_in;
      conf_ff     <= conf_in;
      rsp_data_ff <= rsp_data_in;
      rd_in_ff    <= (pix_ff < count_ff);
      rd_addr_ff  <= mem_raddr;
   end

   // positive store
   always_ff @(posedge clock) begin
      if (pos_we) pos_mem[rd_addr_ff] <= q_val;
      pos_rd_ff <= pos_mem[mem_raddr];
   end

   // negative store
   always_ff @(posedge clock) begin
      if (neg_we) neg_mem[rd_addr_ff] <= q_val;
      neg_rd_ff <= neg_mem[mem_raddr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign release_out = done_ff;

`ifndef ASSERT_OFF
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == BK_ACC || state_ff == BK_COPY))
      else $error("store read pipeline active outside copy or accumulate");

   a_release_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (state_ff == BK_IDLE))
      else $error("patch released while back end still busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (pvc_ff <= CntW'(MaxExamples)) && (nvc_ff <= CntW'(MaxExamples)))
      else $error("valid example count beyond store size");

   a_math_wait: assert property (@(posedge clock) disable iff (reset)
      math_done |-> (state_ff == BK_SQRT || state_ff == BK_DIV || state_ff == BK_CDIV))
      else $error("math unit finished while nobody waits for it");
`endif

endmodule

[hw/rtl/ncc_nearest_neighbour_confidence.sv]
// Nearest-neighbour confidence classifier.
// req channel: one signed pixel per word in raster order; the word with
// last_pixel ends the patch and its req_type selects add positive, add
// negative, classify or clear. Pixels past the patch size are dropped,
// missing ones count as zero.
// rsp channel: one word per patch with the confidence (Q0.16, classify only)
// and the valid example counts after the operation.
// csr port: index 0 example capacity, index 1 fixed count; write while idle.
// Timing: pixels stream in at one per cycle. Once a patch is complete the
// input stalls until the back end has finished it. An add writes the patch
// into the store, one store write a cycle. A classify reads one pixel a cycle
// per example from the store read port, then runs a bit-serial square root
// and divide in a shared unit. The accumulator is 22 bits wide at 15x15.
// Reset empties both stores logically (counts and ring indices to zero) and
// restores the register defaults. A stalled result waits in the output
// register while the next patch is already being loaded.
module ncc_nearest_neighbour_confidence #(
   parameter int PatchW      = nncc_pkg::PatchWDefault,
   parameter int PatchH      = nncc_pkg::PatchHDefault,
   parameter int MaxExamples = nncc_pkg::MaxExamplesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  nncc_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output nncc_pkg::rsp_word_type rsp_data,
   input  logic                   csr_we,
   input  logic [0:0]             csr_index,
   input  logic [8:0]             csr_wdata
);
   import nncc_pkg::*;

   localparam int Pix = PatchW * PatchH;
   localparam int QiW = $clog2(Pix);

   logic [8:0]        cap_ff;
   logic [7:0]        fixed_ff;
   logic              push_valid, queue_full, cmd_valid, cmd_pop, release_w;
   cmd_word_type      push_data, cmd_data;
   logic [QiW-1:0]    q_addr;
   logic signed [7:0] q_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CapacityReset;
         fixed_ff <= FixedReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAPACITY: cap_ff   <= csr_wdata;
            CSR_FIXED:    fixed_ff <= csr_wdata[7:0];
            default:      cap_ff   <= cap_ff;
         endcase
      end
   end

   nncc_front #(.Pix(Pix)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_data  (push_data),
      .queue_full (queue_full),
      .release_in (release_w),
      .q_addr     (q_addr),
      .q_data     (q_data)
   );

   nncc_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (cmd_pop),
      .pop_valid  (cmd_valid),
      .pop_data   (cmd_data)
   );

   nncc_back #(
      .PatchW      (PatchW),
      .PatchH      (PatchH),
      .MaxExamples (MaxExamples)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop),
      .q_addr      (q_addr),
      .q_data      (q_data),
      .cap_cfg     (cap_ff),
      .fixed_cfg   (fixed_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .release_out (release_w)
   );

endmodule

[tb/tb_top.sv]
module tb_top;
   import nncc_pkg::*;

   localparam int PatchPix   = PatchWDefault * PatchHDefault;
   localparam int MaxEx      = MaxExamplesDefault;
   localparam int IdleLimit  = 1000000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;
   logic         csr_we;
   logic [0:0]   csr_index;
   logic [8:0]   csr_wdata;

   ncc_nearest_neighbour_confidence u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic signed [7:0] pos_store [MaxEx][PatchPix];
   logic signed [7:0] neg_store [MaxEx][PatchPix];
   logic signed [7:0] query [PatchPix];
   int unsigned pos_idx, neg_idx, pos_valid, neg_valid, pix_cnt;
   logic [8:0]  capacity_reg;
   logic [7:0]  fixed_reg;

   rsp_word_type expected_words [$];
   int          errors;
   int          idle_cycles;
   int          long_hold_req;
   bit          quiet_rsp;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic int unsigned eff_capacity();
      int unsigned c;
      c = capacity_reg;
      if (c == 0) c = 1;
      if (c > MaxEx) c = MaxEx;
      return c;
   endfunction

   function automatic int unsigned ring_start(int unsigned c);
      return (fixed_reg < c) ? fixed_reg : 0;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // ncc of the query against one stored example, q1.16
   function automatic longint unsigned ncc_score(bit positive, int slot);
      longint s1, s2, s3, a, b;
      longint unsigned r;
      s1 = 0; s2 = 0; s3 = 0;
      for (int i = 0; i < PatchPix; i++) begin
         a = query[i];
         b = positive ? pos_store[slot][i] : neg_store[slot][i];
         s1 += a * a;
         s2 += b * b;
         s3 += a * b;
      end
      if (s1 == 0 || s2 == 0 || s3 <= 0) return 0;
      r = floor_sqrt(longint'(s1) * longint'(s2));
      if (r == 0) return 0;
      return (longint'(s3) << 16) / r;
   endfunction

   function automatic longint unsigned best_score(bit positive, int unsigned cnt);
      longint unsigned best, s;
      best = 0;
      for (int i = 0; i < cnt && i < MaxEx; i++) begin
         s = ncc_score(positive, i);
         if (s > best) best = s;
      end
      return best;
   endfunction

   function automatic logic [15:0] confidence_of();
      longint unsigned n, p, c;
      n = 65536 - best_score(1'b0, neg_valid);
      p = 65536 - best_score(1'b1, pos_valid);
      if (n == 0 || n + p == 0) return 16'd0;
      c = (n << 16) / (n + p);
      return (c > 65535) ? 16'hffff : c[15:0];
   endfunction

   task automatic store_example(bit positive);
      int unsigned c, idx, vld;
      c = eff_capacity();
      idx = positive ? pos_idx : neg_idx;
      vld = positive ? pos_valid : neg_valid;
      if (idx >= c) idx = ring_start(c);
      for (int i = 0; i < PatchPix; i++) begin
         if (positive) pos_store[idx][i] = query[i];
         else neg_store[idx][i] = query[i];
      end
      idx++;
      if (vld < c) vld = idx;
      if (idx >= c) idx = ring_start(c);
      if (positive) begin
         pos_idx = idx; pos_valid = vld;
      end else begin
         neg_idx = idx; neg_valid = vld;
      end
   endtask

   // advance the predictor by one word; returns 1 with the expected word
   task automatic predict_word(input req_word_type w, output bit has,
                               output rsp_word_type r);
      r = '0;
      has = 1'b0;
      if (pix_cnt < PatchPix) begin
         query[pix_cnt] = w.pixel;
         pix_cnt++;
      end
      if (w.last_pixel) begin
         has = 1'b1;
         case (req_kind_type'(w.req_type))
            REQ_ADD_POS: store_example(1'b1);
            REQ_ADD_NEG: store_example(1'b0);
            REQ_CLASSIFY: r.confidence = confidence_of();
            default: begin
               pos_idx = 0; neg_idx = 0; pos_valid = 0; neg_valid = 0;
            end
         endcase
         for (int i = 0; i < PatchPix; i++) query[i] = 0;
         pix_cnt = 0;
         r.positive_count = pos_valid[8:0];
         r.negative_count = neg_valid[8:0];
      end
   endtask

   // send one word, random gap in front; with a typed expectation if given
   task automatic send_word(req_word_type w, bit typed, rsp_word_type typed_rsp);
      int gap;
      bit has;
      rsp_word_type r;
      gap = 0;
      if (!quiet_rsp && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      predict_word(w, has, r);
      if (has) expected_words.push_back(typed ? typed_rsp : r);
   endtask

   task automatic send_patch(req_kind_type kind, req_kind_type early_kind, int len,
                             int fill, bit rand_pix, bit typed, rsp_word_type t);
      req_word_type w;
      for (int i = 0; i < len; i++) begin
         w.last_pixel = (i == len - 1);
         w.req_type   = w.last_pixel ? kind : early_kind;
         w.pixel      = rand_pix ? 8'($urandom) : 8'(fill);
         send_word(w, typed, t);
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [8:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_CAPACITY) capacity_reg = value;
      else fixed_reg = value[7:0];
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (expected_words.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   // result checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no handshake for %0d cycles", IdleLimit);
            $display("ncc_nearest_neighbour_confidence regression: fail");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected result word", 1, 0);
            end else begin
               rsp_word_type e;
               e = expected_words.pop_front();
               if (rsp_data.confidence !== e.confidence)
                  report_mismatch("confidence", rsp_data.confidence, e.confidence);
               if (rsp_data.positive_count !== e.positive_count)
                  report_mismatch("positive_count", rsp_data.positive_count, e.positive_count);
               if (rsp_data.negative_count !== e.negative_count)
                  report_mismatch("negative_count", rsp_data.negative_count, e.negative_count);
            end
         end
      end
   end

   // receiver stall pattern, long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req > 0) begin
            stall_left = long_hold_req;
            long_hold_req = 0;
         end
         if (stall_left == 0 && !quiet_rsp && $urandom_range(0, 99) < 35)
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                     : $urandom_range(1, 4);
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   typedef struct {
      req_kind_type kind;
      req_kind_type early_kind;
      int           len;
      int           fill;
      bit           typed;
      rsp_word_type rsp;
   } patch_row_type;

   typedef struct {
      int cap;
      int fixd;
      int items;
      int classify_pct;
      bit quiet;
   } phase_type;

   // main sequence
   initial begin
      patch_row_type rows [9];
      phase_type     phases [10];
      rsp_word_type  none;
      req_kind_type  kind;
      int            sent, len, roll;

      none = '0;
      errors = 0;
      idle_cycles = 0;
      long_hold_req = 0;
      quiet_rsp = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pos_idx = 0; neg_idx = 0; pos_valid = 0; neg_valid = 0; pix_cnt = 0;
      capacity_reg = CapacityReset;
      fixed_reg = FixedReset;
      for (int s = 0; s < MaxEx; s++)
         for (int i = 0; i < PatchPix; i++) begin
            pos_store[s][i] = 0;
            neg_store[s][i] = 0;
         end
      for (int i = 0; i < PatchPix; i++) query[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed patches: empty model, extremes, mixed types, clear
      rows[0] = '{REQ_CLASSIFY, REQ_CLASSIFY, 1, 0, 1, '{16'd32768, 9'd0, 9'd0}};
      rows[1] = '{REQ_ADD_POS, REQ_ADD_POS, 1, 127, 1, '{16'd0, 9'd1, 9'd0}};
      rows[2] = '{REQ_ADD_NEG, REQ_ADD_NEG, 1, -128, 1, '{16'd0, 9'd1, 9'd1}};
      rows[3] = '{REQ_CLASSIFY, REQ_CLASSIFY, 1, 127, 1, '{16'd65535, 9'd1, 9'd1}};
      rows[4] = '{REQ_CLASSIFY, REQ_CLASSIFY, 1, -128, 1, '{16'd0, 9'd1, 9'd1}};
      rows[5] = '{REQ_CLASSIFY, REQ_ADD_NEG, 2, 1, 0, none};
      rows[6] = '{REQ_ADD_POS, REQ_CLEAR, 3, -1, 0, none};
      rows[7] = '{REQ_CLEAR, REQ_ADD_POS, 1, 9, 1, '{16'd0, 9'd0, 9'd0}};
      rows[8] = '{REQ_CLASSIFY, REQ_CLASSIFY, 1, 5, 1, '{16'd32768, 9'd0, 9'd0}};
      foreach (rows[k])
         send_patch(rows[k].kind, rows[k].early_kind, rows[k].len, rows[k].fill, 1'b0,
                    rows[k].typed, rows[k].rsp);
      drain();

      // register settings, extremes and out-of-range values among them
      phases[0] = '{200, 50, 50, 25, 0};
      phases[1] = '{1, 0, 40, 25, 0};
      phases[2] = '{0, 0, 30, 25, 1};
      phases[3] = '{4, 2, 60, 20, 0};
      phases[4] = '{4, 7, 40, 20, 0};
      phases[5] = '{300, 10, 40, 20, 0};
      phases[6] = '{256, 255, 265, 0, 0};
      phases[7] = '{3, 1, 50, 20, 0};
      phases[8] = '{511, 0, 40, 15, 0};
      phases[9] = '{2, 1, 60, 25, 0};
      foreach (phases[p]) begin
         quiet_rsp = phases[p].quiet;
         write_csr(CSR_CAPACITY, phases[p].cap[8:0]);
         write_csr(CSR_FIXED, phases[p].fixd[8:0]);
         if (p == 3) long_hold_req = 3000;
         sent = 0;
         while (sent < phases[p].items) begin
            roll = $urandom_range(0, 99);
            if (roll < phases[p].classify_pct) kind = REQ_CLASSIFY;
            else if (phases[p].classify_pct > 0 && roll >= 96) kind = REQ_CLEAR;
            else kind = (phases[p].classify_pct == 0 && roll < 5) ? REQ_ADD_NEG :
                        (roll[0] ? REQ_ADD_POS : REQ_ADD_NEG);
            if (phases[p].classify_pct == 0) len = 1;
            else if ($urandom_range(0, 59) == 0 && p != 3) len = $urandom_range(226, 230);
            else if ($urandom_range(0, 6) == 0) len = $urandom_range(7, 30);
            else len = $urandom_range(1, 6);
            send_patch(kind, req_kind_type'($urandom_range(0, 3)), len, 0, 1'b1,
                       1'b0, none);
            sent += len;
         end
         // after an add-only phase, one classify over the stored examples
         if (phases[p].classify_pct == 0)
            send_patch(REQ_CLASSIFY, REQ_CLASSIFY, $urandom_range(1, 4), 0, 1'b1, 1'b0, none);
         drain();
      end

      if (errors == 0) begin
         $display("ncc_nearest_neighbour_confidence regression: pass");
      end else begin
         $display("ncc_nearest_neighbour_confidence regression: fail");
      end
      $finish;
   end

endmodule
